>>> hdl/rpd_pkg.sv
package rpd_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int SAMPLE_MAX    = 4095;
  localparam int SAMPLE_FIELDS = 10;

  localparam int MEAN_W   = 12;
  localparam int SPREAD_W = 8;
  localparam int SPREAD_MAX = 255;
  localparam int VOTES_W  = 4;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [MEAN_W-1:0]   MEAN_LIMIT_RST   = MEAN_W'(60);
  localparam logic [SPREAD_W-1:0] SPREAD_LIMIT_RST = SPREAD_W'(10);
  localparam logic [VOTES_W-1:0]  LOW_VOTES_RST    = VOTES_W'(3);
  localparam logic [VOTES_W-1:0]  HIGH_VOTES_RST   = VOTES_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_LIMIT,
    CFG_SPREAD_LIMIT,
    CFG_LOW_VOTES,
    CFG_HIGH_VOTES
  } cfg_idx_e;

  // what the merge stage found about one window
  typedef struct packed {
    logic steady;
    logic near;
  } win_flags_t;

endpackage

>>> hdl/rpd_lane.sv
module rpd_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic [rpd_pkg::SAMPLE_W-1:0]   sample_o,
  output logic [2*rpd_pkg::SAMPLE_W-1:0] square_o
);
  import rpd_pkg::*;

  logic [SAMPLE_W-1:0]   sample_q;
  logic [2*SAMPLE_W-1:0] square_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_i;
      square_q <= (2*SAMPLE_W)'(sample_i) * (2*SAMPLE_W)'(sample_i);
    end
  end

  assign sample_o = sample_q;
  assign square_o = square_q;

endmodule

>>> hdl/rpd_merge.sv
module rpd_merge #(
  parameter int LANES = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sum_en_i,
  input  logic                           sq_en_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]   samples_i [LANES],
  input  logic [2*rpd_pkg::SAMPLE_W-1:0] squares_i [LANES],
  input  logic [rpd_pkg::MEAN_W-1:0]     mean_limit_i,
  input  logic [rpd_pkg::SPREAD_W-1:0]   spread_limit_i,
  output rpd_pkg::win_flags_t            flags_o
);
  import rpd_pkg::*;

  localparam int SUM_W = $clog2(LANES*SAMPLE_MAX + 1);
  localparam int SQ_W  = $clog2(LANES*SAMPLE_MAX*SAMPLE_MAX + 1);
  localparam int CMP_W = 2*SUM_W;
  localparam int LIM_W = 2*$clog2(LANES*SPREAD_MAX + 1);
  localparam int SLSQ_W = 2*SPREAD_W;

  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [SQ_W-1:0]   sumsq_d, sumsq_q;
  logic [CMP_W-1:0]  sum_sq_q, nsumsq_q;
  logic              near_q;
  logic [SLSQ_W-1:0] sl_sq_q;
  logic [LIM_W-1:0]  lim_q;

  always_comb begin
    sum_d   = '0;
    sumsq_d = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_d   = sum_d + SUM_W'(samples_i[l]);
      sumsq_d = sumsq_d + SQ_W'(squares_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
    end
    if (sq_en_i) begin
      sum_sq_q <= CMP_W'(sum_q) * CMP_W'(sum_q);
      nsumsq_q <= CMP_W'(sumsq_q) * CMP_W'(LANES);
      near_q   <= sum_q < (SUM_W'(mean_limit_i) * SUM_W'(LANES));
    end
  end

  // n^2 * spread_limit^2, formed from the spread limit input through sl_sq_q and then lim_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_sq_q <= SLSQ_W'(SPREAD_LIMIT_RST) * SLSQ_W'(SPREAD_LIMIT_RST);
      lim_q   <= LIM_W'(SLSQ_W'(SPREAD_LIMIT_RST) * SLSQ_W'(SPREAD_LIMIT_RST))
                 * LIM_W'(LANES*LANES);
    end else begin
      sl_sq_q <= SLSQ_W'(spread_limit_i) * SLSQ_W'(spread_limit_i);
      lim_q   <= LIM_W'(sl_sq_q) * LIM_W'(LANES*LANES);
    end
  end

  assign flags_o.steady = (nsumsq_q - sum_sq_q) < CMP_W'(lim_q);
  assign flags_o.near   = near_q;

endmodule

>>> hdl/range_presence_detector.sv
// Presence detector over windows of distance samples. One window is taken per
// clock cycle unless in_stall_o is high. A lane stage squares each sample, a
// merge stage forms sum and sum of squares, a second merge stage forms the two
// products of the spread test, and the vote stage updates the raw flag, the
// vote history and the voted output register. Stall on the output backs up
// stage by stage, so empty stages keep taking windows. The mean limit is
// sampled as a window enters the second merge stage; the spread limit passes
// through sl_sq_q and lim_q in the merge block before the vote stage uses it.
module range_presence_detector #(
  parameter int WINDOW_LEN = 10,
  parameter int VOTE_DEPTH = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_0_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_1_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_2_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_3_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_4_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_5_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_6_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_7_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_8_i,
  input  logic [rpd_pkg::SAMPLE_W-1:0]     sample_9_i,
  input  logic                             cfg_we_i,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rpd_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             person_present_o,
  output logic                             raw_present_o,
  output logic [rpd_pkg::VOTES_W-1:0]      vote_count_o
);
  import rpd_pkg::*;

  localparam int LANES = (WINDOW_LEN < SAMPLE_FIELDS) ? WINDOW_LEN : SAMPLE_FIELDS;
  localparam int CNT_W = $clog2(VOTE_DEPTH + 1);
  localparam int TH_W  = (CNT_W > VOTES_W) ? CNT_W : VOTES_W;

  // configuration
  logic [MEAN_W-1:0]   mean_limit_q;
  logic [SPREAD_W-1:0] spread_limit_q;
  logic [VOTES_W-1:0]  low_votes_q, high_votes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_limit_q   <= MEAN_LIMIT_RST;
      spread_limit_q <= SPREAD_LIMIT_RST;
      low_votes_q    <= LOW_VOTES_RST;
      high_votes_q   <= HIGH_VOTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MEAN_LIMIT:   mean_limit_q   <= cfg_data_i[MEAN_W-1:0];
        CFG_SPREAD_LIMIT: spread_limit_q <= cfg_data_i[SPREAD_W-1:0];
        CFG_LOW_VOTES:    low_votes_q    <= cfg_data_i[VOTES_W-1:0];
        CFG_HIGH_VOTES:   high_votes_q   <= cfg_data_i[VOTES_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy and backpressure
  logic lane_v_q, sum_v_q, sq_v_q, out_v_q;
  logic lane_rdy, sum_rdy, sq_rdy, out_rdy;

  assign out_rdy  = !out_v_q || !out_stall_i;
  assign sq_rdy   = !sq_v_q || out_rdy;
  assign sum_rdy  = !sum_v_q || sq_rdy;
  assign lane_rdy = !lane_v_q || sum_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
      sq_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (lane_rdy) lane_v_q <= in_valid_i;
      if (sum_rdy)  sum_v_q  <= lane_v_q;
      if (sq_rdy)   sq_v_q   <= sum_v_q;
      if (out_rdy)  out_v_q  <= sq_v_q;
    end
  end

  assign in_stall_o = !lane_rdy;

  // lanes
  logic [SAMPLE_W-1:0]   samples [SAMPLE_FIELDS];
  logic [SAMPLE_W-1:0]   lane_sample [LANES];
  logic [2*SAMPLE_W-1:0] lane_square [LANES];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;
  assign samples[8] = sample_8_i;
  assign samples[9] = sample_9_i;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rpd_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_rdy && in_valid_i),
      .sample_i (samples[l]),
      .sample_o (lane_sample[l]),
      .square_o (lane_square[l])
    );
  end

  win_flags_t flags;

  rpd_merge #(.LANES(LANES)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sum_en_i       (sum_rdy && lane_v_q),
    .sq_en_i        (sq_rdy && sum_v_q),
    .samples_i      (lane_sample),
    .squares_i      (lane_square),
    .mean_limit_i   (mean_limit_q),
    .spread_limit_i (spread_limit_q),
    .flags_o        (flags)
  );

  // vote stage
  logic                  out_load;
  logic                  raw_d, raw_q;
  logic                  voted_d, voted_q;
  logic [VOTE_DEPTH-1:0] vote_hist_d, vote_hist_q;
  logic [CNT_W-1:0]      vote_cnt_d, vote_cnt_q;

  assign out_load = out_rdy && sq_v_q;

  always_comb begin
    raw_d       = flags.steady ? flags.near : raw_q;
    vote_hist_d = {vote_hist_q[VOTE_DEPTH-2:0], raw_d};
    // running count: add the new vote, drop the one shifted out
    vote_cnt_d  = vote_cnt_q + CNT_W'(raw_d) - CNT_W'(vote_hist_q[VOTE_DEPTH-1]);
    voted_d     = voted_q;
    if (TH_W'(vote_cnt_d) <= TH_W'(low_votes_q))  voted_d = 1'b0;
    if (TH_W'(vote_cnt_d) >= TH_W'(high_votes_q)) voted_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b0;
      voted_q     <= 1'b0;
      vote_hist_q <= '0;
      vote_cnt_q  <= '0;
    end else if (out_load) begin
      raw_q       <= raw_d;
      voted_q     <= voted_d;
      vote_hist_q <= vote_hist_d;
      vote_cnt_q  <= vote_cnt_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign person_present_o = voted_q;
  assign raw_present_o    = raw_q;
  assign vote_count_o     = (TH_W'(vote_cnt_q) > TH_W'(15)) ? VOTES_W'(15)
                                                            : VOTES_W'(TH_W'(vote_cnt_q));

  a_cnt_matches_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vote_cnt_q == CNT_W'($countones(vote_hist_q)))
    else $error("vote count out of step with history");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vote_hist_q) && $stable(voted_q))
    else $error("vote state changed while result stalled");

  a_high_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (TH_W'(vote_cnt_q) < TH_W'(high_votes_q)) || voted_q)
    else $error("voted flag not set at high vote count");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lane_v_q |-> !in_stall_o)
    else $error("empty lane stage refused a request");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rpd_pkg::*;

  localparam int WINDOW_LEN     = 10;
  localparam int VOTE_DEPTH     = 11;
  localparam int PHASE_WINDOWS  = 43;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 100;

  typedef logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] window_t;

  typedef struct packed {
    logic               person;
    logic               raw;
    logic [VOTES_W-1:0] count;
  } decision_t;

  typedef enum int {WIN_NEAR, WIN_FAR, WIN_EDGE, WIN_NOISE} window_kind_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  window_t              in_window = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 person_present_o;
  logic                 raw_present_o;
  logic [VOTES_W-1:0]   vote_count_o;

  // limits as the block should hold them
  logic [MEAN_W-1:0]    lim_mean = MEAN_LIMIT_RST;
  logic [SPREAD_W-1:0]  lim_spread = SPREAD_LIMIT_RST;
  logic [VOTES_W-1:0]   lim_low = LOW_VOTES_RST;
  logic [VOTES_W-1:0]   lim_high = HIGH_VOTES_RST;

  // detector state as the block should hold it
  logic                  near_flag = 1'b0;
  logic [VOTE_DEPTH-1:0] vote_hist = '0;
  logic                  voted = 1'b0;

  window_t   queued_windows[$];
  decision_t pending_decisions[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_span = 0;
  stall_mode_e stall_mode = STALL_NONE;

  logic in_taken, out_taken;
  assign in_taken  = in_valid_i && !in_stall_o;
  assign out_taken = out_valid_o && !out_stall_i;

  range_presence_detector #(
    .WINDOW_LEN(WINDOW_LEN),
    .VOTE_DEPTH(VOTE_DEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_0_i      (in_window[0]),
    .sample_1_i      (in_window[1]),
    .sample_2_i      (in_window[2]),
    .sample_3_i      (in_window[3]),
    .sample_4_i      (in_window[4]),
    .sample_5_i      (in_window[5]),
    .sample_6_i      (in_window[6]),
    .sample_7_i      (in_window[7]),
    .sample_8_i      (in_window[8]),
    .sample_9_i      (in_window[9]),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .person_present_o(person_present_o),
    .raw_present_o   (raw_present_o),
    .vote_count_o    (vote_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic decision_t predict_decision(window_t w);
    logic [63:0] total, total_sq, spread, limit_sq;
    int unsigned votes;
    decision_t d;
    total = '0;
    total_sq = '0;
    for (int k = 0; k < WINDOW_LEN && k < SAMPLE_FIELDS; k++) begin
      total    = total + 64'(w[k]);
      total_sq = total_sq + 64'(w[k]) * 64'(w[k]);
    end
    spread   = 64'(WINDOW_LEN) * total_sq - total * total;
    limit_sq = 64'(WINDOW_LEN) * 64'(WINDOW_LEN) * 64'(lim_spread) * 64'(lim_spread);
    // unsteady windows leave the raw flag alone
    if (spread < limit_sq) begin
      near_flag = (total < 64'(WINDOW_LEN) * 64'(lim_mean));
    end
    vote_hist = {vote_hist[VOTE_DEPTH-2:0], near_flag};
    votes = $countones(vote_hist);
    if (votes <= lim_low) begin
      voted = 1'b0;
    end
    if (votes >= lim_high) begin
      voted = 1'b1;
    end
    d.person = voted;
    d.raw    = near_flag;
    d.count  = (votes > 15) ? VOTES_W'(15) : VOTES_W'(votes);
    return d;
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (queued_windows.size() > 0) begin
        in_window <= queued_windows.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between modes after spans of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_span <= $urandom_range(16, 96);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni) begin
      if (in_taken) begin
        pending_decisions.push_back(predict_decision(in_window));
      end
      if (out_taken) begin
        if (pending_decisions.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = pending_decisions.pop_front();
          if (person_present_o !== want.person) begin
            flag_mismatch($sformatf("person_present %b, want %b",
                                    person_present_o, want.person));
          end
          if (raw_present_o !== want.raw) begin
            flag_mismatch($sformatf("raw_present %b, want %b", raw_present_o, want.raw));
          end
          if (vote_count_o !== want.count) begin
            flag_mismatch($sformatf("vote_count %0d, want %0d", vote_count_o, want.count));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_taken || out_taken || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic window_t flat_window(int value);
    window_t w;
    for (int k = 0; k < SAMPLE_FIELDS; k++) begin
      w[k] = SAMPLE_W'(value);
    end
    return w;
  endfunction

  function automatic window_t split_window(int a, int b);
    window_t w;
    for (int k = 0; k < SAMPLE_FIELDS; k++) begin
      w[k] = (k % 2 == 0) ? SAMPLE_W'(a) : SAMPLE_W'(b);
    end
    return w;
  endfunction

  function automatic window_t make_window(window_kind_e kind);
    window_t w;
    int base, jit, s;
    case (kind)
      WIN_NEAR: base = (lim_mean > 0) ? int'($urandom_range(0, lim_mean - 1)) : 0;
      WIN_FAR:  base = int'($urandom_range(lim_mean, SAMPLE_MAX));
      WIN_EDGE: base = int'(lim_mean) + int'($urandom_range(0, 2)) - 1;
      default:  base = 0;
    endcase
    // a jitter below the spread limit keeps the window steady
    if (kind == WIN_EDGE) begin
      jit = int'(lim_spread);
    end else begin
      jit = (lim_spread > 0) ? int'($urandom_range(0, lim_spread - 1)) : 0;
    end
    for (int k = 0; k < SAMPLE_FIELDS; k++) begin
      if (kind == WIN_NOISE) begin
        case ($urandom_range(0, 5))
          0:       s = 0;
          1:       s = SAMPLE_MAX;
          default: s = int'($urandom_range(0, SAMPLE_MAX));
        endcase
      end else begin
        s = base + int'($urandom_range(0, 2 * jit)) - jit;
      end
      if (s < 0) begin
        s = 0;
      end
      if (s > SAMPLE_MAX) begin
        s = SAMPLE_MAX;
      end
      w[k] = SAMPLE_W'(s);
    end
    return w;
  endfunction

  task automatic queue_random_windows(int count);
    window_kind_e kind;
    int pick, run;
    int made;
    made = 0;
    // runs of one kind drive the vote count up and down
    while (made < count) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? WIN_NEAR : (pick < 7) ? WIN_FAR : (pick < 8) ? WIN_EDGE : WIN_NOISE;
      run = $urandom_range(1, 12);
      for (int k = 0; k < run && made < count; k++) begin
        queued_windows.push_back(make_window(kind));
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (queued_windows.size() != 0 || in_valid_i || pending_decisions.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_MEAN_LIMIT:   lim_mean = value[MEAN_W-1:0];
      CFG_SPREAD_LIMIT: lim_spread = value[SPREAD_W-1:0];
      CFG_LOW_VOTES:    lim_low = value[VOTES_W-1:0];
      default:          lim_high = value[VOTES_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // upper data bits carry junk that the block must drop
  task automatic set_limits(int mean, int spread, int low, int high);
    write_reg(CFG_MEAN_LIMIT, CFG_W'(mean));
    write_reg(CFG_SPREAD_LIMIT, {4'($urandom), 8'(spread)});
    write_reg(CFG_LOW_VOTES, {8'($urandom), 4'(low)});
    write_reg(CFG_HIGH_VOTES, {8'($urandom), 4'(high)});
    repeat (3) @(negedge clk_i);
  endtask

  task automatic run_phase(int mean, int spread, int low, int high);
    set_limits(mean, spread, low, high);
    queue_random_windows(PHASE_WINDOWS);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed windows under the reset limits
    queued_windows.push_back(flat_window(0));
    queued_windows.push_back(flat_window(SAMPLE_MAX));
    queued_windows.push_back(flat_window('haaa));
    queued_windows.push_back(flat_window('h555));
    repeat (8) queued_windows.push_back(flat_window(30));
    queued_windows.push_back(split_window(50, 70));
    queued_windows.push_back(split_window(51, 69));
    queued_windows.push_back(flat_window(59));
    queued_windows.push_back(flat_window(60));
    queued_windows.push_back(split_window(0, SAMPLE_MAX));
    repeat (7) queued_windows.push_back(flat_window(SAMPLE_MAX));
    wait_drained();

    run_phase(60, 10, 3, 8);
    run_phase(200, 40, 3, 8);
    run_phase(SAMPLE_MAX, SPREAD_MAX, 0, 11);
    // nothing is steady; low at depth always clears, high of zero sets and wins
    run_phase(0, 0, 11, 0);
    run_phase(1000, 100, 7, 4);
    // thresholds above the vote depth
    run_phase(300, 20, 12, 15);
    run_phase(0, SPREAD_MAX, 2, 9);
    run_phase(150, 1, 5, 6);
    run_phase(2500, 60, 4, 7);
    run_phase($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SPREAD_MAX),
              $urandom_range(0, 15), $urandom_range(0, 15));

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && pending_decisions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
